[design/csp_pkg.sv]
// csp_pkg: shared types and constants for the CSR pattern SpMV block.
// No dependencies; imported by csp_front, csp_back and csr_pattern_spmv.
package csp_pkg;

  localparam int PRODUCT_W = 38;
  localparam int OUT_ROWS_MAX = 64;
  localparam logic [6:0] ENTRY_COUNT_MAX = 7'd127;

  localparam logic [2:0] OP_APPEND = 3'd0;
  localparam logic [2:0] OP_CLOSE = 3'd1;
  localparam logic [2:0] OP_VEC_WR = 3'd2;
  localparam logic [2:0] OP_MULTIPLY = 3'd3;
  localparam logic [2:0] OP_QUERY = 3'd4;

  localparam logic KIND_PRODUCT = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  typedef struct packed {
    logic [2:0] op;
    logic [5:0] row;
    logic [5:0] column;
    logic signed [31:0] value;
  } item_t;

  // front -> back handshake on the item queue
  typedef struct packed {
    logic  valid;
    item_t item;
  } queue_head_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CLOSE,
    S_ROW_RD,
    S_WALK,
    S_COL_WAIT,
    S_VEC_WAIT,
    S_EMIT,
    S_Q_RD0,
    S_Q_RD1,
    S_Q_WALK,
    S_Q_CMP,
    S_Q_EMIT
  } back_state_e;

endpackage

[design/csr_pattern_spmv.sv]
// csr_pattern_spmv: a word queue feeds a sequencer over the CSR stores.
// Append and vector write finish in idle; close adds a row start write. Multiply walks each
// row: a row start read, then per entry a column read and a vector read. Query reads two row
// starts, then scans to a match or a larger column. Two queued words let input run ahead.
// Reset clears control, fill and entry counts, row start valid bits; row_count = 64.
// Depends on csp_pkg, csp_front and csp_back.
module csr_pattern_spmv #(
  parameter int ROWS_MAX = 64,
  parameter int NONZERO_MAX = 1024,
  parameter int VALUE_BITS = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [2:0]          op_i,
  input  logic [5:0]          row_i,
  input  logic [5:0]          column_i,
  input  logic signed [31:0]  value_i,
  input  logic                cfg_we_i,
  input  logic [6:0]          cfg_wdata_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic                kind_o,
  output logic [5:0]          out_row_o,
  output logic signed [37:0]  product_o,
  output logic                present_o,
  output logic                last_o
);
  import csp_pkg::*;

  item_t       in_item;
  queue_head_t head;
  logic        pop;

  // pack the incoming word for the queue
  assign in_item.op = op_i;
  assign in_item.row = row_i;
  assign in_item.column = column_i;
  assign in_item.value = value_i;

  // front: two-entry word queue, stalls only when full
  csp_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .item_i     (in_item),
    .head_o     (head),
    .pop_i      (pop)
  );

  // back: sequencer over the stores, with its own output register
  csp_back #(
    .ROWS_MAX    (ROWS_MAX),
    .NONZERO_MAX (NONZERO_MAX),
    .VALUE_BITS  (VALUE_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .pop_o       (pop),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .kind_o      (kind_o),
    .out_row_o   (out_row_o),
    .product_o   (product_o),
    .present_o   (present_o),
    .last_o      (last_o)
  );

endmodule

[design/csp_front.sv]
// csp_front: accepts input words into a two-entry queue.
// Depends on csp_pkg (item_t, queue_head_t).
module csp_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  csp_pkg::item_t       item_i,
  output csp_pkg::queue_head_t head_o,
  input  logic                 pop_i
);
  import csp_pkg::*;

  item_t      slot_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;
  logic       push, pop;

  assign in_stall_o = (count_q == 2'd2);
  assign push = in_valid_i && !in_stall_o;
  assign pop = pop_i && (count_q != 2'd0);
  assign head_o.valid = (count_q != 2'd0);
  assign head_o.item = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? !rd_ptr_q : rd_ptr_q;
    count_d = count_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

[design/csp_back.sv]
// csp_back: executes queued words against the column, row start and vector stores.
// Depends on csp_pkg (item_t, queue_head_t, back_state_e, op codes).
module csp_back #(
  parameter int ROWS_MAX = 64,
  parameter int NONZERO_MAX = 1024,
  parameter int VALUE_BITS = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  csp_pkg::queue_head_t          head_i,
  output logic                          pop_o,
  input  logic                          cfg_we_i,
  input  logic [6:0]                    cfg_wdata_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          kind_o,
  output logic [5:0]                    out_row_o,
  output logic signed [csp_pkg::PRODUCT_W-1:0] product_o,
  output logic                          present_o,
  output logic                          last_o
);
  import csp_pkg::*;

  localparam int FW = $clog2(NONZERO_MAX + 1);
  localparam int CAW = $clog2(NONZERO_MAX);
  localparam int RSAW = $clog2(ROWS_MAX + 1);
  localparam int VAW = $clog2(ROWS_MAX);
  localparam int SW = ((VALUE_BITS > PRODUCT_W) ? VALUE_BITS : PRODUCT_W) + 1;
  localparam int NW = FW + 8;
  localparam logic signed [SW-1:0] P_HI =
    signed'({{(SW-PRODUCT_W+1){1'b0}}, {(PRODUCT_W-1){1'b1}}});
  localparam logic signed [SW-1:0] P_LO =
    signed'({{(SW-PRODUCT_W+1){1'b1}}, {(PRODUCT_W-1){1'b0}}});

  // stores
  logic [5:0]                  col_mem [NONZERO_MAX];
  logic [FW-1:0]               rs_mem [ROWS_MAX+1];
  logic [ROWS_MAX:0]           rs_vld_q;
  logic signed [VALUE_BITS-1:0] vec_mem [ROWS_MAX];

  logic                  col_we, vec_we, rs_we;
  logic [CAW-1:0]        col_wa, col_ra;
  logic [VAW-1:0]        vec_wa, vec_ra;
  logic [RSAW-1:0]       rs_wa, rs_ra;
  logic [5:0]            col_wd, col_rd_q;
  logic signed [VALUE_BITS-1:0] vec_wd, vec_rd_q;
  logic [FW-1:0]         rs_wd, rs_rd_q, rs_val;
  logic                  rs_vld_rd_q;

  back_state_e state_q, state_d;
  item_t       hd;
  logic [5:0]  row_q, row_d, col_q, col_d;
  logic [6:0]  i_q, i_d, n_q, n_d, n_eff, row_count_q, row_count_d;
  logic [FW-1:0] start_q, start_d, finish_q, finish_d, k_q, k_d, fill_q, fill_d;
  logic [6:0]  rec_q, rec_d;
  logic signed [PRODUCT_W-1:0] sum_q, sum_d;
  logic        colok_q, colok_d, present_q, present_d;
  logic [NW-1:0] nxt;
  logic signed [SW-1:0] sum_x, elem_x, acc_x;
  logic        out_free, out_load;
  logic        ld_kind, ld_present, ld_last;
  logic [5:0]  ld_row;
  logic signed [PRODUCT_W-1:0] ld_prod;

  assign hd = head_i.item;
  assign rs_val = rs_vld_rd_q ? rs_rd_q : '0;
  assign out_free = !out_valid_o || !out_stall_i;

  always_comb begin
    n_eff = row_count_q;
    if (32'(n_eff) > ROWS_MAX) n_eff = 7'(ROWS_MAX);
    if (32'(n_eff) > OUT_ROWS_MAX) n_eff = 7'(OUT_ROWS_MAX);
  end

  // saturating accumulate of the fetched vector element
  always_comb begin
    sum_x = SW'(sum_q);
    elem_x = colok_q ? SW'(vec_rd_q) : '0;
    acc_x = sum_x + elem_x;
  end

  always_comb begin
    nxt = NW'(rs_val) + NW'(rec_q);
    if (nxt > NW'(NONZERO_MAX)) nxt = NW'(NONZERO_MAX);
  end

  always_comb begin
    state_d = state_q;
    row_d = row_q;
    col_d = col_q;
    i_d = i_q;
    n_d = n_q;
    start_d = start_q;
    finish_d = finish_q;
    k_d = k_q;
    fill_d = fill_q;
    rec_d = rec_q;
    sum_d = sum_q;
    colok_d = colok_q;
    present_d = present_q;
    row_count_d = cfg_we_i ? cfg_wdata_i : row_count_q;
    pop_o = 1'b0;
    col_we = 1'b0;
    col_wa = fill_q[CAW-1:0];
    col_wd = hd.column;
    col_ra = k_q[CAW-1:0];
    vec_we = 1'b0;
    vec_wa = VAW'(hd.column);
    vec_wd = VALUE_BITS'(hd.value);
    vec_ra = VAW'(col_rd_q);
    rs_we = 1'b0;
    rs_wa = RSAW'(32'(row_q) + 1);
    rs_wd = FW'(nxt);
    rs_ra = RSAW'(32'(hd.row));
    out_load = 1'b0;
    ld_kind = KIND_PRODUCT;
    ld_row = i_q[5:0];
    ld_prod = sum_q;
    ld_present = 1'b0;
    ld_last = (i_q + 7'd1 == n_q);

    case (state_q)
      S_IDLE: begin
        if (head_i.valid) begin
          pop_o = 1'b1;
          row_d = hd.row;
          col_d = hd.column;
          case (hd.op)
            OP_APPEND: begin
              if (fill_q < FW'(NONZERO_MAX)) begin
                col_we = 1'b1;
                fill_d = fill_q + 1'b1;
                if (rec_q < ENTRY_COUNT_MAX) rec_d = rec_q + 7'd1;
              end
            end
            OP_CLOSE: begin
              if (32'(hd.row) < ROWS_MAX) state_d = S_CLOSE;
            end
            OP_VEC_WR: begin
              if (32'(hd.column) < ROWS_MAX) vec_we = 1'b1;
            end
            OP_MULTIPLY: begin
              n_d = n_eff;
              i_d = 7'd0;
              start_d = '0;
              rs_ra = RSAW'(1);
              if (n_eff != 7'd0) state_d = S_ROW_RD;
            end
            OP_QUERY: begin
              present_d = 1'b0;
              if (32'(hd.row) < ROWS_MAX) state_d = S_Q_RD0;
              else state_d = S_Q_EMIT;
            end
            default: ;
          endcase
        end
      end
      S_CLOSE: begin
        rs_we = 1'b1;
        rec_d = 7'd0;
        state_d = S_IDLE;
      end
      S_ROW_RD: begin
        finish_d = rs_val;
        k_d = start_q;
        sum_d = '0;
        state_d = S_WALK;
      end
      S_WALK: begin
        if (k_q >= finish_q) state_d = S_EMIT;
        else state_d = S_COL_WAIT;
      end
      S_COL_WAIT: begin
        colok_d = (32'(col_rd_q) < ROWS_MAX);
        state_d = S_VEC_WAIT;
      end
      S_VEC_WAIT: begin
        if (acc_x > P_HI) sum_d = PRODUCT_W'(P_HI);
        else if (acc_x < P_LO) sum_d = PRODUCT_W'(P_LO);
        else sum_d = PRODUCT_W'(acc_x);
        k_d = k_q + 1'b1;
        state_d = S_WALK;
      end
      S_EMIT: begin
        rs_ra = RSAW'(32'(i_q) + 2);
        if (out_free) begin
          out_load = 1'b1;
          if (ld_last) begin
            state_d = S_IDLE;
          end else begin
            i_d = i_q + 7'd1;
            start_d = finish_q;
            state_d = S_ROW_RD;
          end
        end
      end
      S_Q_RD0: begin
        start_d = rs_val;
        rs_ra = RSAW'(32'(row_q) + 1);
        state_d = S_Q_RD1;
      end
      S_Q_RD1: begin
        finish_d = rs_val;
        k_d = start_q;
        state_d = S_Q_WALK;
      end
      S_Q_WALK: begin
        if (k_q >= finish_q) state_d = S_Q_EMIT;
        else state_d = S_Q_CMP;
      end
      S_Q_CMP: begin
        if (col_rd_q == col_q) begin
          present_d = 1'b1;
          state_d = S_Q_EMIT;
        end else if (col_rd_q > col_q) begin
          state_d = S_Q_EMIT;
        end else begin
          k_d = k_q + 1'b1;
          state_d = S_Q_WALK;
        end
      end
      S_Q_EMIT: begin
        ld_kind = KIND_QUERY;
        ld_row = row_q;
        ld_prod = '0;
        ld_present = present_q;
        ld_last = 1'b1;
        if (out_free) begin
          out_load = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      fill_q <= '0;
      rec_q <= 7'd0;
      row_count_q <= 7'd64;
      rs_vld_q <= '0;
      out_valid_o <= 1'b0;
    end else begin
      state_q <= state_d;
      fill_q <= fill_d;
      rec_q <= rec_d;
      row_count_q <= row_count_d;
      if (rs_we) rs_vld_q[rs_wa] <= 1'b1;
      if (out_load) out_valid_o <= 1'b1;
      else if (!out_stall_i) out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    row_q <= row_d;
    col_q <= col_d;
    i_q <= i_d;
    n_q <= n_d;
    start_q <= start_d;
    finish_q <= finish_d;
    k_q <= k_d;
    sum_q <= sum_d;
    colok_q <= colok_d;
    present_q <= present_d;
    if (out_load) begin
      kind_o <= ld_kind;
      out_row_o <= ld_row;
      product_o <= ld_prod;
      present_o <= ld_present;
      last_o <= ld_last;
    end
  end

  // memories, registered read
  always_ff @(posedge clk_i) begin
    if (col_we) col_mem[col_wa] <= col_wd;
    col_rd_q <= col_mem[col_ra];
  end

  always_ff @(posedge clk_i) begin
    if (vec_we) vec_mem[vec_wa] <= vec_wd;
    vec_rd_q <= vec_mem[vec_ra];
  end

  always_ff @(posedge clk_i) begin
    if (rs_we) rs_mem[rs_wa] <= rs_wd;
    rs_rd_q <= rs_mem[rs_ra];
    rs_vld_rd_q <= rs_vld_q[rs_ra];
  end

endmodule

[design/csp_checker.sv]
// csp_checker: port-level assertions for csr_pattern_spmv, bound to the top level.
// Depends only on the top level's ports.
module csp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic        kind_o,
  input logic [5:0]  out_row_o,
  input logic [37:0] product_o,
  input logic        present_o,
  input logic        last_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(product_o) && $stable(out_row_o))
    else $error("result changed while stalled");

  a_product_no_present: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !kind_o |-> !present_o)
    else $error("product word with present set");

  a_query_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o |-> last_o && (product_o == 38'd0))
    else $error("query answer malformed");

  a_row_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !kind_o && !last_o ##1 out_valid_o && !kind_o
    |-> out_row_o != 6'd0)
    else $error("product rows out of order");

endmodule

bind csr_pattern_spmv csp_checker u_csp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .kind_o      (kind_o),
  .out_row_o   (out_row_o),
  .product_o   (product_o),
  .present_o   (present_o),
  .last_o      (last_o)
);
